// ===== rtl/mif_pkg.sv =====
// ----------------------------------------------------------------------------
// mif_pkg: shared constants and types of the modular inverse pipeline
// Modulus, Barrett factor, exponent and the beat formats that travel
// between neighboring cells.
// ----------------------------------------------------------------------------
package mif_pkg;

  // Field widths.
  localparam int OperandW = 63;
  localparam int ResW     = 30;

  // Prime modulus and the Fermat exponent p-2.
  localparam logic [ResW-1:0] Prime    = 30'd998244353;
  localparam logic [ResW-1:0] ExpConst = Prime - 30'd2;
  localparam int              ExpBits  = ResW;

  // The top bits of the operand already sit below the prime, so the
  // reduction chain only has to fold in the remaining low bits.
  localparam int RedSteps = OperandW - (ResW - 1);

  // Barrett reduction for products below 2^(2*ResW).
  localparam int              ProdW      = 2 * ResW;
  localparam int              MuW        = ResW + 1;
  localparam int              RemW       = ResW + 2;
  localparam logic [63:0]     MuFull     = (64'd1 << ProdW) / {34'd0, Prime};
  localparam logic [MuW-1:0]  BarrettMu  = MuFull[MuW-1:0];
  localparam logic [RemW-1:0] PrimeW     = {2'b00, Prime};
  localparam logic [RemW-1:0] TwoPrimeW  = {1'b0, Prime, 1'b0};

  // Pipeline depth of one modular multiplier.
  localparam int MulLat = 4;

  // Beat handed along the reduction chain.
  typedef struct packed {
    logic                valid;
    logic [RedSteps-1:0] rem;
    logic [ResW-1:0]     res;
  } red_beat_t;

  // Beat handed along the exponentiation chain.
  typedef struct packed {
    logic            valid;
    logic [ResW-1:0] acc;
    logic [ResW-1:0] base;
  } exp_beat_t;

endpackage

// ===== rtl/mif_op_if.sv =====
// ----------------------------------------------------------------------------
// mif_op_if: operand channel
// Valid/ready channel that carries one operand per beat.
// ----------------------------------------------------------------------------
interface mif_op_if;
  import mif_pkg::*;

  logic                valid;
  logic                ready;
  logic [OperandW-1:0] operand;

  modport source (output valid, output operand, input ready);
  modport sink   (input valid, input operand, output ready);
endinterface

// ===== rtl/mif_res_if.sv =====
// ----------------------------------------------------------------------------
// mif_res_if: result channel
// Valid/ready channel that carries one modular inverse per beat.
// ----------------------------------------------------------------------------
interface mif_res_if;
  import mif_pkg::*;

  logic            valid;
  logic            ready;
  logic [ResW-1:0] inverse;

  modport source (output valid, output inverse, input ready);
  modport sink   (input valid, input inverse, output ready);
endinterface

// ===== rtl/mif_red_cell.sv =====
// ----------------------------------------------------------------------------
// mif_red_cell: one step of the operand reduction chain
// Shifts the next operand bit into the running residue and subtracts the
// prime once when the residue reaches it.
// ----------------------------------------------------------------------------
module mif_red_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  mif_pkg::red_beat_t  beat_i,
  output mif_pkg::red_beat_t  beat_o
);
  import mif_pkg::*;

  logic                valid_q;
  logic [RedSteps-1:0] rem_q;
  logic [ResW-1:0]     res_q;
  logic [ResW:0]       shifted;
  logic [ResW:0]       diff;
  logic [ResW-1:0]     res_d;

  // The residue stays below the prime, so 2r+b is below twice the prime.
  assign shifted = {beat_i.res, beat_i.rem[RedSteps-1]};
  assign diff    = shifted - {1'b0, Prime};
  assign res_d   = (shifted >= {1'b0, Prime}) ? diff[ResW-1:0] : shifted[ResW-1:0];

  // Valid flag of the beat held in this cell.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= beat_i.valid;
    end
  end

  // Residue and the bits still to be folded in.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q <= {beat_i.rem[RedSteps-2:0], 1'b0};
      res_q <= res_d;
    end
  end

  assign beat_o = '{valid: valid_q, rem: rem_q, res: res_q};

endmodule

// ===== rtl/mif_mulmod.sv =====
// ----------------------------------------------------------------------------
// mif_mulmod: pipelined multiplier modulo the prime
// Four stages: product, Barrett quotient estimate, quotient times prime,
// and the final subtract with up to two corrections.
// ----------------------------------------------------------------------------
module mif_mulmod (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic [mif_pkg::ResW-1:0] a_i,
  input  logic [mif_pkg::ResW-1:0] b_i,
  output logic [mif_pkg::ResW-1:0] p_o
);
  import mif_pkg::*;

  logic [ProdW-1:0]   prod_q;
  logic [2*MuW-1:0]   est;
  logic [ResW-1:0]    qhat_q;
  logic [RemW-1:0]    low1_q;
  logic [ProdW-1:0]   qp_full;
  logic [RemW-1:0]    qp_q;
  logic [RemW-1:0]    low2_q;
  logic [RemW-1:0]    rem;
  logic [RemW-1:0]    rem_fix;
  logic [ResW-1:0]    p_q;

  // Quotient estimate from the top bits of the product.
  assign est = {{MuW{1'b0}}, prod_q[ProdW-1:ResW-1]} * {{MuW{1'b0}}, BarrettMu};

  // Only the low bits of quotient times prime matter: the remainder is below 3p.
  assign qp_full = {{ResW{1'b0}}, qhat_q} * {{ResW{1'b0}}, Prime};

  // Remainder estimate and its correction into [0, p).
  assign rem = low2_q - qp_q;

  always_comb begin
    if (rem >= TwoPrimeW) begin
      rem_fix = rem - TwoPrimeW;
    end else if (rem >= PrimeW) begin
      rem_fix = rem - PrimeW;
    end else begin
      rem_fix = rem;
    end
  end

  // Pipeline registers, all advancing together.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= {{ResW{1'b0}}, a_i} * {{ResW{1'b0}}, b_i};
      qhat_q <= est[MuW+ResW-1:MuW];
      low1_q <= prod_q[RemW-1:0];
      qp_q   <= qp_full[RemW-1:0];
      low2_q <= low1_q;
      p_q    <= rem_fix[ResW-1:0];
    end
  end

  assign p_o = p_q;

endmodule

// ===== rtl/mif_exp_cell.sv =====
// ----------------------------------------------------------------------------
// mif_exp_cell: one exponent bit of square-and-multiply
// Multiplies the accumulator by the base when the exponent bit is set and
// squares the base, both in parallel multipliers of equal depth.
// ----------------------------------------------------------------------------
module mif_exp_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                bit_i,
  input  mif_pkg::exp_beat_t  beat_i,
  output mif_pkg::exp_beat_t  beat_o
);
  import mif_pkg::*;

  logic [MulLat-1:0] valid_q;
  logic [ResW-1:0]   factor;
  logic [ResW-1:0]   acc_p;
  logic [ResW-1:0]   base_p;

  // A clear bit multiplies by one, which leaves the accumulator as it is.
  assign factor = bit_i ? beat_i.base : ResW'(1);

  mif_mulmod u_acc_mul (
    .clk_i (clk_i),
    .en_i  (en_i),
    .a_i   (beat_i.acc),
    .b_i   (factor),
    .p_o   (acc_p)
  );

  mif_mulmod u_sqr_mul (
    .clk_i (clk_i),
    .en_i  (en_i),
    .a_i   (beat_i.base),
    .b_i   (beat_i.base),
    .p_o   (base_p)
  );

  // Valid flags follow the data through the multiplier stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[MulLat-2:0], beat_i.valid};
    end
  end

  assign beat_o = '{valid: valid_q[MulLat-1], acc: acc_p, base: base_p};

endmodule

// ===== rtl/modular_inverse_fermat.sv =====
// ----------------------------------------------------------------------------
// modular_inverse_fermat: inverse modulo 998244353 by Fermat's theorem
// Reduces a 63-bit operand modulo the prime, then raises the residue to
// p-2 with one square-and-multiply cell per exponent bit.
// ----------------------------------------------------------------------------
//
//   Channel  Dir  Width  Meaning
//   op_i     in   63     operand to invert
//   res_o    out  30     operand^(p-2) mod p, zero for multiples of p
//
// One beat is accepted per cycle while the skid register is free. A beat
// passes 34 reduction cells, 30 exponent cells as deep as the modular
// multiplier each, and the output register on its way to the result.
// Reset clears only the valid flags; no clearing pass is needed.
// The chain stalls as a whole only when both the output register and the
// skid register are full; op_i.ready comes from a register.
//
module modular_inverse_fermat (
  input  logic      clk_i,
  input  logic      rst_ni,
  mif_op_if.sink    op_i,
  mif_res_if.source res_o
);
  import mif_pkg::*;

  red_beat_t       red_chain [RedSteps+1];
  exp_beat_t       exp_chain [ExpBits+1];
  logic            en;
  logic            push;
  logic            pop;
  logic            out_valid_q;
  logic [ResW-1:0] out_data_q;
  logic            skid_valid_q;
  logic [ResW-1:0] skid_data_q;

  // The chain moves whenever the skid register is free.
  assign en       = !skid_valid_q;
  assign op_i.ready = en;

  // Top operand bits already lie below the prime.
  assign red_chain[0] = '{
    valid: op_i.valid,
    rem:   op_i.operand[RedSteps-1:0],
    res:   ResW'(op_i.operand[OperandW-1:RedSteps])
  };

  // Reduction chain, one operand bit per cell.
  for (genvar g = 0; g < RedSteps; g++) begin : g_red
    mif_red_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .beat_i (red_chain[g]),
      .beat_o (red_chain[g+1])
    );
  end

  assign exp_chain[0] = '{
    valid: red_chain[RedSteps].valid,
    acc:   ResW'(1),
    base:  red_chain[RedSteps].res
  };

  // Exponentiation chain, least significant exponent bit first.
  for (genvar g = 0; g < ExpBits; g++) begin : g_exp
    mif_exp_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .bit_i  (ExpConst[g]),
      .beat_i (exp_chain[g]),
      .beat_o (exp_chain[g+1])
    );
  end

  // Output register with a skid register behind it.
  assign push = en && exp_chain[ExpBits].valid;
  assign pop  = out_valid_q && res_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (pop) begin
        skid_valid_q <= 1'b0;
      end
    end else if (push) begin
      if (out_valid_q && !pop) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (pop) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (pop) begin
        out_data_q <= skid_data_q;
      end
    end else if (push) begin
      if (out_valid_q && !pop) begin
        skid_data_q <= exp_chain[ExpBits].acc;
      end else begin
        out_data_q <= exp_chain[ExpBits].acc;
      end
    end
  end

  assign res_o.valid   = out_valid_q;
  assign res_o.inverse = out_data_q;

  // A held skid beat always has an output beat in front of it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid register holds a beat while the output is empty");

  // A beat arriving at a blocked output is parked in the skid register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && out_valid_q && !res_o.ready) |=> skid_valid_q)
    else $error("result beat dropped at a blocked output");

  // The residue leaving the reduction chain is fully reduced.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    red_chain[RedSteps].valid |-> (red_chain[RedSteps].res < Prime))
    else $error("reduction chain produced a residue not below the prime");

  // Every delivered inverse lies below the prime.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_data_q < Prime))
    else $error("inverse not below the prime");

endmodule
